FILE: src/order_book_indicative_volume_defines.svh
// Assertion macros for the order book indicative volume block.
// No dependencies; modules that assert include this file.
`ifndef ORDER_BOOK_INDICATIVE_VOLUME_DEFINES_SVH
`define ORDER_BOOK_INDICATIVE_VOLUME_DEFINES_SVH

// same-cycle implication, checked at every clk edge out of reset
`define OBIV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OBIV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/obiv_pkg.sv
// Shared types, codes and helpers of the order book indicative volume block.
// No dependencies.
package obiv_pkg;

	localparam logic [7:0] SIDE_BUY  = 8'd66;
	localparam logic [7:0] SIDE_SELL = 8'd83;

	localparam logic [2:0] KIND_ADD  = 3'd0;
	localparam logic [2:0] KIND_DEL  = 3'd1;
	localparam logic [2:0] KIND_EXEC = 3'd2;
	localparam logic [2:0] KIND_RST  = 3'd3;
	localparam logic [2:0] KIND_QRY  = 3'd4;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_UNKNOWN = 3'd1;
	localparam logic [2:0] STAT_BADSIDE = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_IGNORED = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] order_ref;
		logic [7:0]  side;
		logic        is_market;
		logic [31:0] price;
		logic [31:0] quantity;
		logic        reset_flag;
	} obiv_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] bid_sum;
		logic [47:0] ask_sum;
		logic [47:0] match_volume;
	} obiv_res_t;

	// one resting order
	typedef struct packed {
		logic        used;
		logic [31:0] order_ref;
		logic        is_sell;
		logic        is_market;
		logic [31:0] price;
		logic [31:0] qty;
	} obiv_ord_t;

	// one price level
	typedef struct packed {
		logic        used;
		logic [31:0] price;
		logic [47:0] qty;
	} obiv_lvl_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_OSCAN, S_TSCAN, S_TWR, S_PSCAN, S_PWR, S_OWR, S_QSCAN, S_FIN
	} obiv_state_t;

	function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? '1 : s[47:0];
	endfunction

	function automatic logic [47:0] floor_sub(input logic [47:0] a, input logic [47:0] b);
		return (b >= a) ? '0 : a - b;
	endfunction

endpackage

FILE: src/obiv_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module obiv_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/order_book_indicative_volume.sv
// Order book indicative volume: order table, level tables, control sequencer.
// Depends on obiv_pkg, obiv_ram and order_book_indicative_volume_defines.svh.
//
// Usage: raise start with a command on cmd while busy is low; the command is
// transferred at that edge. Exactly one result per command comes back on
// result, valid for the single cycle in which done is high; the receiver
// cannot stall it, so it must take the transfer in that cycle. busy stays
// high from the transfer until the done cycle has passed. The work per command
// is set by linear scans over the memories, one entry per cycle:
//   add:     an order scan, then level scans for the old and new price
//            (each only for a limit order), then the writes
//   delete / execute: an order scan, a level scan if limit, then the writes
//   query:   one scan over both halves of the level table
//   reset with flag: a clearing pass over both tables, then the result
//   others:  the result directly
// After arst_n the same clearing pass runs with busy high and no result.
module order_book_indicative_volume #(
	parameter int ORDER_SLOTS = 1024,
	parameter int LEVEL_SLOTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  obiv_pkg::obiv_cmd_t  cmd,
	output logic                 done,
	output obiv_pkg::obiv_res_t  result
);
	import obiv_pkg::*;
	`include "order_book_indicative_volume_defines.svh"

	localparam int OAW       = $clog2(ORDER_SLOTS);
	localparam int LAW       = $clog2(LEVEL_SLOTS);
	localparam int LVL_DEPTH = 2 ** (LAW + 1);     // bid half then ask half
	localparam int NCLR      = (ORDER_SLOTS > LVL_DEPTH) ? ORDER_SLOTS : LVL_DEPTH;
	localparam int CW        = $clog2(NCLR + 1);
	localparam int OW        = $bits(obiv_ord_t);
	localparam int LW        = $bits(obiv_lvl_t);

	obiv_state_t state_q, state_d;

	// latched command and scan bookkeeping
	obiv_cmd_t      cmd_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  addr_s1;
	logic           rvalid_s1;
	logic           found_q, free_found_q, lfound_q, lfree_found_q, fail_q, clr_reply_q;
	logic [OAW-1:0] fidx_q, free_idx_q;
	logic [LAW-1:0] lidx_q, lfree_q;
	logic [47:0]    lqty_q;
	obiv_ord_t      fent_q;
	logic [31:0]    tq_q;
	logic [2:0]     status_q;
	logic [47:0]    qbuy_q, qsell_q, mkt_buy_q, mkt_sell_q;

	// memory ports
	logic               ord_we, lvl_we;
	logic [OAW-1:0]     ord_waddr;
	logic [LAW:0]       lvl_waddr, lvl_raddr;
	obiv_ord_t          ord_wdata, ord_rd;
	obiv_lvl_t          lvl_wdata, lvl_rd;
	logic [OW-1:0]      ord_rdata;
	logic [LW-1:0]      lvl_rdata;

	// scan control
	logic           in_scan, issue, scan_end;
	logic [CW-1:0]  lim;
	logic           scan_sell;
	logic [31:0]    scan_price;
	logic           new_sell;
	logic [31:0]    tq_c;
	logic [31:0]    new_oqty;
	obiv_state_t    put_next, after_take;

	assign ord_rd   = obiv_ord_t'(ord_rdata);
	assign lvl_rd   = obiv_lvl_t'(lvl_rdata);
	assign new_sell = (cmd_q.side == SIDE_SELL);

	// take-out amount: whole order, or execute capped at resting quantity
	assign tq_c     = (cmd_q.kind == KIND_EXEC && cmd_q.quantity < fent_q.qty)
		? cmd_q.quantity : fent_q.qty;
	assign new_oqty = fent_q.qty - tq_q;

	always_comb begin
		in_scan = (state_q == S_OSCAN) || (state_q == S_TSCAN)
			|| (state_q == S_PSCAN) || (state_q == S_QSCAN);
		unique case (state_q)
			S_OSCAN: lim = CW'(ORDER_SLOTS);
			S_QSCAN: lim = CW'(LVL_DEPTH);
			default: lim = CW'(LEVEL_SLOTS);
		endcase
		issue    = in_scan && (cnt_q < lim);
		scan_end = in_scan && !issue && !rvalid_s1;
		// take-out walks the old side/price; put-in the new one
		scan_sell  = (state_q == S_TSCAN) ? fent_q.is_sell : new_sell;
		scan_price = (state_q == S_TSCAN) ? fent_q.price : cmd_q.price;
	end

	// next state
	always_comb begin
		put_next   = cmd_q.is_market ? S_OWR : S_PSCAN;
		after_take = (cmd_q.kind == KIND_ADD) ? put_next : S_OWR;
		state_d    = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (cnt_q == CW'(NCLR - 1)) state_d = clr_reply_q ? S_FIN : S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					unique case (cmd.kind)
						KIND_ADD: state_d = (cmd.side == SIDE_BUY || cmd.side == SIDE_SELL)
							? S_OSCAN : S_FIN;
						KIND_DEL, KIND_EXEC: state_d = S_OSCAN;
						KIND_RST: state_d = cmd.reset_flag ? S_CLEAR : S_FIN;
						KIND_QRY: state_d = S_QSCAN;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_OSCAN: begin
				if (scan_end) begin
					priority if (found_q) begin
						state_d = fent_q.is_market ? after_take : S_TSCAN;
					end else if (cmd_q.kind == KIND_ADD && free_found_q) begin
						state_d = put_next;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_TSCAN: begin
				if (scan_end) state_d = lfound_q ? S_TWR : after_take;
			end
			S_TWR: state_d = after_take;
			S_PSCAN: begin
				if (scan_end) begin
					priority if (lfound_q || lfree_found_q) state_d = S_PWR;
					else if (found_q) state_d = S_OWR;
					else state_d = S_FIN;
				end
			end
			S_PWR:   state_d = S_OWR;
			S_OWR:   state_d = S_FIN;
			S_QSCAN: begin
				if (scan_end) state_d = S_FIN;
			end
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// memory port drive
	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = found_q ? fidx_q : free_idx_q;
		ord_wdata = '0;
		lvl_we    = 1'b0;
		lvl_waddr = {scan_sell, lidx_q};
		lvl_wdata = '0;
		lvl_raddr = (state_q == S_QSCAN) ? cnt_q[LAW:0] : {scan_sell, cnt_q[LAW-1:0]};
		unique case (state_q)
			S_CLEAR: begin
				ord_we    = (cnt_q < CW'(ORDER_SLOTS));
				ord_waddr = cnt_q[OAW-1:0];
				lvl_we    = (cnt_q < CW'(LVL_DEPTH));
				lvl_waddr = cnt_q[LAW:0];
			end
			S_TWR: begin
				lvl_we    = 1'b1;
				lvl_waddr = {fent_q.is_sell, lidx_q};
				lvl_wdata.used  = ({16'd0, tq_q} < lqty_q);
				lvl_wdata.price = fent_q.price;
				lvl_wdata.qty   = lqty_q - {16'd0, tq_q};
			end
			S_PWR: begin
				lvl_we    = 1'b1;
				lvl_waddr = {new_sell, lfound_q ? lidx_q : lfree_q};
				lvl_wdata.used  = 1'b1;
				lvl_wdata.price = cmd_q.price;
				lvl_wdata.qty   = sat_add(lfound_q ? lqty_q : 48'd0, {16'd0, cmd_q.quantity});
			end
			S_OWR: begin
				ord_we = 1'b1;
				if (cmd_q.kind == KIND_ADD) begin
					ord_wdata.used      = !fail_q;
					ord_wdata.order_ref = cmd_q.order_ref;
					ord_wdata.is_sell   = new_sell;
					ord_wdata.is_market = cmd_q.is_market;
					ord_wdata.price     = cmd_q.price;
					ord_wdata.qty       = cmd_q.quantity;
				end else begin
					ord_wdata      = fent_q;
					ord_wdata.qty  = new_oqty;
					ord_wdata.used = (cmd_q.kind == KIND_EXEC) && (new_oqty != 32'd0);
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rvalid_s1   <= 1'b0;
			clr_reply_q <= 1'b0;
			mkt_buy_q   <= '0;
			mkt_sell_q  <= '0;
		end else begin
			rvalid_s1 <= issue;
			if (state_d != state_q) cnt_q <= '0;
			else if (issue || state_q == S_CLEAR) cnt_q <= cnt_q + CW'(1);
			if (state_q == S_IDLE && start) begin
				clr_reply_q <= 1'b1;
				if (cmd.kind == KIND_RST && cmd.reset_flag) begin
					mkt_buy_q  <= '0;
					mkt_sell_q <= '0;
				end
			end else if (state_q == S_FIN) begin
				clr_reply_q <= 1'b0;
			end
			// market take-out once the old order is known
			if (state_q == S_OSCAN && scan_end && found_q && fent_q.is_market) begin
				if (fent_q.is_sell) mkt_sell_q <= floor_sub(mkt_sell_q, {16'd0, tq_c});
				else mkt_buy_q <= floor_sub(mkt_buy_q, {16'd0, tq_c});
			end
			// market put-in together with the order write
			if (state_q == S_OWR && cmd_q.kind == KIND_ADD && cmd_q.is_market) begin
				if (new_sell) mkt_sell_q <= sat_add(mkt_sell_q, {16'd0, cmd_q.quantity});
				else mkt_buy_q <= sat_add(mkt_buy_q, {16'd0, cmd_q.quantity});
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		if (state_q == S_IDLE && start) begin
			cmd_q        <= cmd;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			fail_q       <= 1'b0;
			qbuy_q       <= (cmd.kind == KIND_QRY) ? mkt_buy_q : '0;
			qsell_q      <= (cmd.kind == KIND_QRY) ? mkt_sell_q : '0;
			priority if (cmd.kind == KIND_ADD && cmd.side != SIDE_BUY && cmd.side != SIDE_SELL)
				status_q <= STAT_BADSIDE;
			else if (cmd.kind == KIND_RST && !cmd.reset_flag)
				status_q <= STAT_IGNORED;
			else
				status_q <= STAT_OK;
		end
		if ((state_d == S_TSCAN || state_d == S_PSCAN) && state_d != state_q) begin
			lfound_q      <= 1'b0;
			lfree_found_q <= 1'b0;
		end
		if (rvalid_s1) begin
			unique case (state_q)
				S_OSCAN: begin
					if (ord_rd.used && ord_rd.order_ref == cmd_q.order_ref && !found_q) begin
						found_q <= 1'b1;
						fidx_q  <= addr_s1[OAW-1:0];
						fent_q  <= ord_rd;
					end
					if (!ord_rd.used && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= addr_s1[OAW-1:0];
					end
				end
				S_TSCAN, S_PSCAN: begin
					if (lvl_rd.used && lvl_rd.price == scan_price && !lfound_q) begin
						lfound_q <= 1'b1;
						lidx_q   <= addr_s1[LAW-1:0];
						lqty_q   <= lvl_rd.qty;
					end
					if (!lvl_rd.used && !lfree_found_q) begin
						lfree_found_q <= 1'b1;
						lfree_q       <= addr_s1[LAW-1:0];
					end
				end
				S_QSCAN: begin
					if (lvl_rd.used) begin
						if (!addr_s1[LAW] && (cmd_q.is_market || lvl_rd.price >= cmd_q.price))
							qbuy_q <= sat_add(qbuy_q, lvl_rd.qty);
						if (addr_s1[LAW] && (cmd_q.is_market || lvl_rd.price <= cmd_q.price))
							qsell_q <= sat_add(qsell_q, lvl_rd.qty);
					end
				end
				default: ;
			endcase
		end
		if (state_q == S_OSCAN && scan_end) begin
			tq_q <= tq_c;
			if (!found_q) begin
				if (cmd_q.kind == KIND_ADD) begin
					if (!free_found_q) status_q <= STAT_FULL;
				end else begin
					status_q <= STAT_UNKNOWN;
				end
			end
		end
		if (state_q == S_PSCAN && scan_end && !lfound_q && !lfree_found_q) begin
			fail_q   <= 1'b1;
			status_q <= STAT_FULL;
		end
	end

	obiv_ram #(.W(OW), .D(ORDER_SLOTS)) u_ord_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (OW'(ord_wdata)),
		.raddr (cnt_q[OAW-1:0]),
		.rdata (ord_rdata)
	);

	obiv_ram #(.W(LW), .D(LVL_DEPTH)) u_lvl_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_waddr),
		.wdata (LW'(lvl_wdata)),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	assign busy                = (state_q != S_IDLE);
	assign done                = (state_q == S_FIN);
	assign result.status       = status_q;
	assign result.bid_sum      = qbuy_q;
	assign result.ask_sum      = qsell_q;
	assign result.match_volume = (qbuy_q < qsell_q) ? qbuy_q : qsell_q;

	`OBIV_ASSERT_NXT(a_done_pulse, done, !done, "done longer than one cycle")
	`OBIV_ASSERT_NXT(a_take_busy, start && !busy, busy, "transfer not followed by busy")
	`OBIV_ASSERT_IMP(a_both_we, ord_we && lvl_we, state_q == S_CLEAR,
		"order and level writes together outside clearing pass")
	`OBIV_ASSERT_IMP(a_match_min,
		done, result.match_volume <= result.bid_sum && result.match_volume <= result.ask_sum,
		"match volume above a side total")
endmodule

FILE: tb/order_book_indicative_volume_tb.sv
// Testbench for order_book_indicative_volume: directed and random commands
// checked against an in-bench model of the order and level tables.
// Depends on obiv_pkg and the order_book_indicative_volume RTL.
`timescale 1ns / 100ps

module order_book_indicative_volume_tb;
	import obiv_pkg::*;

	localparam int ORDERS = 1024;
	localparam int LEVELS = 256;
	localparam logic [47:0] MAX48 = '1;
	// kinds 5..7 are spare: no effect, status OK
	localparam logic [2:0] KIND_SPARE = 3'd5;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	obiv_cmd_t cmd;
	obiv_res_t result;

	order_book_indicative_volume dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// shadow book
	bit          ord_used [ORDERS];
	logic [31:0] ord_id   [ORDERS];
	bit          ord_sell [ORDERS];
	bit          ord_mkt  [ORDERS];
	logic [31:0] ord_px   [ORDERS];
	logic [31:0] ord_qty  [ORDERS];
	bit          bid_used [LEVELS];
	logic [31:0] bid_px   [LEVELS];
	logic [47:0] bid_qty  [LEVELS];
	bit          ask_used [LEVELS];
	logic [31:0] ask_px   [LEVELS];
	logic [47:0] ask_qty  [LEVELS];
	logic [47:0] mkt_buy, mkt_sell;

	obiv_res_t expected_results[$];
	int errors = 0;
	int transfers = 0;

	function automatic logic [47:0] add_clamped(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? MAX48 : s[47:0];
	endfunction

	function automatic void clear_book();
		foreach (ord_used[i]) ord_used[i] = 0;
		foreach (bid_used[i]) begin
			bid_used[i] = 0;
			ask_used[i] = 0;
		end
		mkt_buy = '0;
		mkt_sell = '0;
	endfunction

	function automatic int lookup_order(logic [31:0] id);
		for (int i = 0; i < ORDERS; i++)
			if (ord_used[i] && ord_id[i] == id) return i;
		return -1;
	endfunction

	// remove q from one side's aggregate; a level at or below q is freed
	function automatic void level_remove(bit sell, bit mkt, logic [31:0] px, logic [47:0] q);
		if (mkt) begin
			if (sell) mkt_sell = (q >= mkt_sell) ? '0 : mkt_sell - q;
			else mkt_buy = (q >= mkt_buy) ? '0 : mkt_buy - q;
			return;
		end
		for (int i = 0; i < LEVELS; i++) begin
			if (sell && ask_used[i] && ask_px[i] == px) begin
				if (q >= ask_qty[i]) ask_used[i] = 0;
				else ask_qty[i] -= q;
				return;
			end
			if (!sell && bid_used[i] && bid_px[i] == px) begin
				if (q >= bid_qty[i]) bid_used[i] = 0;
				else bid_qty[i] -= q;
				return;
			end
		end
	endfunction

	// add q; 0 when a new level is needed and the side table is full
	function automatic bit level_insert(bit sell, bit mkt, logic [31:0] px, logic [47:0] q);
		int lv;
		lv = -1;
		if (mkt) begin
			if (sell) mkt_sell = add_clamped(mkt_sell, q);
			else mkt_buy = add_clamped(mkt_buy, q);
			return 1;
		end
		for (int i = 0; i < LEVELS && lv < 0; i++)
			if (sell ? (ask_used[i] && ask_px[i] == px) : (bid_used[i] && bid_px[i] == px))
				lv = i;
		if (lv < 0) begin
			for (int i = 0; i < LEVELS && lv < 0; i++)
				if (!(sell ? ask_used[i] : bid_used[i])) lv = i;
			if (lv < 0) return 0;
			if (sell) begin
				ask_used[lv] = 1; ask_px[lv] = px; ask_qty[lv] = '0;
			end else begin
				bid_used[lv] = 1; bid_px[lv] = px; bid_qty[lv] = '0;
			end
		end
		if (sell) ask_qty[lv] = add_clamped(ask_qty[lv], q);
		else bid_qty[lv] = add_clamped(bid_qty[lv], q);
		return 1;
	endfunction

	// apply one command to the shadow book, return the result it causes
	function automatic obiv_res_t book_update(obiv_cmd_t c);
		obiv_res_t r;
		int s;
		logic [31:0] ex;
		r = '0;
		r.status = STAT_OK;
		case (c.kind)
			KIND_ADD: begin
				if (c.side != SIDE_BUY && c.side != SIDE_SELL) begin
					r.status = STAT_BADSIDE;
				end else begin
					s = lookup_order(c.order_ref);
					if (s >= 0) begin
						level_remove(ord_sell[s], ord_mkt[s], ord_px[s], {16'd0, ord_qty[s]});
					end else begin
						for (int i = 0; i < ORDERS && s < 0; i++)
							if (!ord_used[i]) s = i;
					end
					if (s < 0) begin
						r.status = STAT_FULL;
					end else if (!level_insert(c.side == SIDE_SELL, c.is_market, c.price,
							{16'd0, c.quantity})) begin
						ord_used[s] = 0;
						r.status = STAT_FULL;
					end else begin
						ord_used[s] = 1;
						ord_id[s] = c.order_ref;
						ord_sell[s] = (c.side == SIDE_SELL);
						ord_mkt[s] = c.is_market;
						ord_px[s] = c.price;
						ord_qty[s] = c.quantity;
					end
				end
			end
			KIND_DEL, KIND_EXEC: begin
				s = lookup_order(c.order_ref);
				if (s < 0) begin
					r.status = STAT_UNKNOWN;
				end else begin
					ex = (c.kind == KIND_DEL || c.quantity > ord_qty[s]) ? ord_qty[s]
						: c.quantity;
					level_remove(ord_sell[s], ord_mkt[s], ord_px[s], {16'd0, ex});
					ord_qty[s] -= ex;
					if (c.kind == KIND_DEL || ord_qty[s] == 0) ord_used[s] = 0;
				end
			end
			KIND_RST: begin
				if (c.reset_flag) clear_book();
				else r.status = STAT_IGNORED;
			end
			KIND_QRY: begin
				r.bid_sum = mkt_buy;
				r.ask_sum = mkt_sell;
				for (int i = 0; i < LEVELS; i++) begin
					if (bid_used[i] && (c.is_market || bid_px[i] >= c.price))
						r.bid_sum = add_clamped(r.bid_sum, bid_qty[i]);
					if (ask_used[i] && (c.is_market || ask_px[i] <= c.price))
						r.ask_sum = add_clamped(r.ask_sum, ask_qty[i]);
				end
				r.match_volume = (r.bid_sum < r.ask_sum) ? r.bid_sum : r.ask_sum;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
		$display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
		errors++;
	endtask

	// result checker: done is a one-cycle strobe, no backpressure
	always @(posedge clk) begin
		obiv_res_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("ERROR %0t: result with no command outstanding", $time);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.bid_sum !== want.bid_sum)
					report_mismatch("bid_sum", result.bid_sum, want.bid_sum);
				if (result.ask_sum !== want.ask_sum)
					report_mismatch("ask_sum", result.ask_sum, want.ask_sum);
				if (result.match_volume !== want.match_volume)
					report_mismatch("match_volume", result.match_volume, want.match_volume);
			end
		end
	end

	// one command transfer; start stays high so a following send keeps it up
	task automatic send_cmd(obiv_cmd_t c);
		// random gaps, except for a long stretch in the middle of the run
		if (!(transfers >= 400 && transfers < 700) && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_results.push_back(book_update(c));
		transfers++;
	endtask

	function automatic obiv_cmd_t make_cmd(logic [2:0] k, logic [31:0] id, logic [7:0] sd,
			bit mkt, logic [31:0] px, logic [31:0] q, bit flag);
		obiv_cmd_t c;
		c.kind = k; c.order_ref = id; c.side = sd; c.is_market = mkt;
		c.price = px; c.quantity = q; c.reset_flag = flag;
		return c;
	endfunction

	task automatic test_directed();
		send_cmd(make_cmd(KIND_ADD, 32'd1, SIDE_BUY, 0, 32'd100, 32'd10, 0));
		send_cmd(make_cmd(KIND_ADD, 32'd2, SIDE_SELL, 0, 32'd90, 32'd7, 0));
		send_cmd(make_cmd(KIND_QRY, '0, '0, 0, 32'd95, '0, 0));
		// market orders and extreme prices / quantities
		send_cmd(make_cmd(KIND_ADD, 32'hFFFF_FFFF, SIDE_BUY, 1, 32'h1234_5678, '1, 1));
		send_cmd(make_cmd(KIND_ADD, 32'd3, SIDE_SELL, 1, '0, 32'd5, 0));
		send_cmd(make_cmd(KIND_ADD, 32'd4, SIDE_SELL, 0, '1, '1, 0));
		send_cmd(make_cmd(KIND_ADD, 32'd0, SIDE_BUY, 0, '0, 32'd3, 0));
		// zero quantity add keeps a level
		send_cmd(make_cmd(KIND_ADD, 32'd5, SIDE_BUY, 0, 32'd50, '0, 0));
		send_cmd(make_cmd(KIND_ADD, 32'd6, 8'hFF, 0, 32'd50, 32'd9, 0));
		send_cmd(make_cmd(KIND_ADD, 32'd6, 8'h00, 1, 32'd50, 32'd9, 0));
		send_cmd(make_cmd(KIND_QRY, '0, '0, 0, '0, '0, 0));
		send_cmd(make_cmd(KIND_QRY, '0, '0, 0, '1, '0, 0));
		send_cmd(make_cmd(KIND_QRY, '0, '1, 1, 32'd77, '1, 1));
		// upsert: flip side and price of order 1
		send_cmd(make_cmd(KIND_ADD, 32'd1, SIDE_SELL, 0, 32'd80, 32'd4, 0));
		// execute beyond resting, execute zero order by zero
		send_cmd(make_cmd(KIND_EXEC, 32'd2, '0, 0, '0, 32'd100, 0));
		send_cmd(make_cmd(KIND_EXEC, 32'd5, '0, 0, '0, '0, 0));
		send_cmd(make_cmd(KIND_EXEC, 32'd3, '0, 0, '0, 32'd2, 0));
		send_cmd(make_cmd(KIND_DEL, 32'hFFFF_FFFF, '0, 0, '0, '0, 0));
		send_cmd(make_cmd(KIND_DEL, 32'd999, '0, 0, '0, '0, 0));
		send_cmd(make_cmd(KIND_EXEC, 32'd999, '0, 0, '0, 32'd1, 0));
		send_cmd(make_cmd(KIND_RST, '0, '0, 0, '0, '0, 0));
		send_cmd(make_cmd(KIND_SPARE, 32'd4, SIDE_BUY, 0, '0, '1, 1));
		send_cmd(make_cmd(KIND_SPARE + 3'd2, '1, '1, 1, '1, '1, 1));
		send_cmd(make_cmd(KIND_QRY, '0, '0, 1, '0, '0, 0));
		send_cmd(make_cmd(KIND_RST, '0, '0, 0, '0, '0, 1));
		send_cmd(make_cmd(KIND_QRY, '0, '0, 1, '0, '0, 0));
	endtask

	// fill every bid level, hit the level limit, then fill the order table
	task automatic test_tables_full();
		for (int i = 0; i < LEVELS; i++)
			send_cmd(make_cmd(KIND_ADD, i, SIDE_BUY, 0, 32'd1000 + i, $urandom_range(1, 500), 0));
		send_cmd(make_cmd(KIND_ADD, 32'd5000, SIDE_BUY, 0, 32'd7, 32'd1, 0));
		// sole order of a level moves to a new price: freed level is reused
		send_cmd(make_cmd(KIND_ADD, 32'd0, SIDE_BUY, 0, 32'd7, 32'd2, 0));
		// same again with all other levels taken: it lands in its own freed level
		send_cmd(make_cmd(KIND_ADD, 32'd3, SIDE_BUY, 0, 32'd9, 32'd2, 0));
		send_cmd(make_cmd(KIND_QRY, '0, '0, 1, '0, '0, 0));
		for (int i = LEVELS; i < ORDERS + 2; i++)
			send_cmd(make_cmd(KIND_ADD, 32'h100 + i, ($urandom_range(0, 1) ? SIDE_BUY : SIDE_SELL),
				$urandom_range(0, 3) == 0, 32'd1000 + $urandom_range(0, 20),
				$urandom_range(0, 1000), 0));
		send_cmd(make_cmd(KIND_QRY, '0, '0, 0, 32'd1010, '0, 0));
		send_cmd(make_cmd(KIND_RST, '0, '0, 0, '0, '0, 1));
	endtask

	task automatic test_random(int count);
		obiv_cmd_t c;
		int pick;
		for (int n = 0; n < count; n++) begin
			c.order_ref = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 47);
			c.side = ($urandom_range(0, 11) == 0) ? 8'($urandom())
				: ($urandom_range(0, 1) ? SIDE_BUY : SIDE_SELL);
			c.is_market = ($urandom_range(0, 7) == 0);
			c.price = ($urandom_range(0, 15) == 0) ? $urandom() : 32'd200 + $urandom_range(0, 30);
			case ($urandom_range(0, 3))
				0: c.quantity = $urandom();
				1: c.quantity = '1;
				default: c.quantity = $urandom_range(0, 300);
			endcase
			c.reset_flag = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 42) c.kind = KIND_ADD;
			else if (pick < 55) c.kind = KIND_DEL;
			else if (pick < 75) c.kind = KIND_EXEC;
			else if (pick < 95) c.kind = KIND_QRY;
			else if (pick < 98) c.kind = KIND_RST;
			else c.kind = KIND_SPARE + 3'($urandom_range(0, 2));
			send_cmd(c);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		clear_book();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_tables_full();
		test_random(260);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	// watchdog for a hung run
	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/obiv_pkg.sv
src/obiv_ram.sv
src/order_book_indicative_volume.sv
tb/order_book_indicative_volume_tb.sv
